/* design/tcbf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcbf_pkg
// Shared result codes and fixed widths of the timestamped chunk byte FIFO.
// ----------------------------------------------------------------------------
package tcbf_pkg;

    localparam int TIME_W = 64;
    localparam int LEN_W  = 7;

    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_GAP    = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_READ   = 1'b1;

endpackage
`default_nettype wire

/* design/timestamped_chunk_byte_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// timestamped_chunk_byte_fifo
// Byte FIFO of time-stamped chunks with age expiry and drop-oldest overflow.
//
// Input channel (in_valid / in_stall): one beat is one byte append (opcode 0)
// or one read request (opcode 1). Output channel (out_valid / out_stall):
// one beat per result; last marks the final result of an input beat.
// Configuration channel (cfg_valid / cfg_ready) writes max_age_us; write it
// only while the block is idle.
// One input beat is handled at a time, and in_stall stays high until the
// block is back in idle. An append steps through S_A_OPEN, S_A_ROOM and
// S_A_WRITE, passing S_DWAIT for each chunk dropped to make room. A read
// that answers a gap or nothing ends in S_R_CHK; one that returns data
// passes S_R_BYTE per byte, with S_R_BWAIT between bytes. A read passes
// S_DWAIT for each expired chunk dropped. Every step reads the chunk table
// and byte memory through registers. A result waits in the output
// register while out_stall is high; the sequencer holds until it is free.
// Reset empties the FIFO, clears the gap flag and sets max_age_us to 1000000.
// No clearing pass is needed: memory entries are only read after written.
// ----------------------------------------------------------------------------
module timestamped_chunk_byte_fifo #(
    parameter int CAPACITY   = 4096,
    parameter int MAX_CHUNKS = 64,
    parameter int MAX_READ   = 64
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              opcode,
    input  wire logic [7:0]                        data_byte,
    input  wire logic                              chunk_end,
    input  wire logic [tcbf_pkg::TIME_W-1:0]       time_us,
    input  wire logic [tcbf_pkg::LEN_W-1:0]        read_length,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [1:0]                             kind,
    output logic [7:0]                             out_byte,
    output logic [tcbf_pkg::TIME_W-1:0]            out_time_us,
    output logic                                   notify,
    output logic                                   last,
    output logic [$clog2(CAPACITY+1)-1:0]          buffered_bytes,
    output logic                                   gap_pending,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [tcbf_pkg::TIME_W-1:0]       cfg_data
);
    import tcbf_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(MAX_CHUNKS);
    localparam int NW = $clog2(MAX_CHUNKS + 1);
    localparam int RW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_A_OPEN, S_A_ROOM, S_A_WRITE, S_R_CHK, S_R_BYTE, S_R_BWAIT, S_DWAIT
    } state_t;

    state_t              state_reg, ret_reg;
    logic [AW-1:0]       byte_head_reg, byte_tail_reg;
    logic [CW-1:0]       chunk_head_reg, open_slot_reg;
    logic [NW-1:0]       count_reg;
    logic [RW-1:0]       total_reg, open_rem_reg, front_rem_reg;
    logic                gap_reg, open_reg, hold_reg;
    logic [TIME_W-1:0]   max_age_reg, open_time_reg, front_time_reg;
    logic                in_end_reg;
    logic [7:0]          in_byte_reg;
    logic [TIME_W-1:0]   in_time_reg;
    logic [LEN_W-1:0]    in_len_reg, cnt_reg;

    logic [7:0]          byte_mem [CAPACITY];
    logic [TIME_W-1:0]   time_mem [MAX_CHUNKS];
    logic [RW-1:0]       rem_mem  [MAX_CHUNKS];
    logic [7:0]          byte_rd_reg;
    logic [TIME_W-1:0]   time_rd_reg;
    logic [RW-1:0]       rem_rd_reg;

    logic                out_valid_reg, out_notify_reg, out_last_reg, out_gap_reg;
    kind_t               out_kind_reg;
    logic [7:0]          out_byte_reg;
    logic [TIME_W-1:0]   out_time_reg;
    logic [RW-1:0]       out_total_reg;

    logic                out_free, full, chunks_full, has_closed, expired, over;
    logic                drop_c, read_done_c, emit_c;
    logic [RW:0]         drop_sum;
    logic [AW-1:0]       drop_head, head_inc, tail_inc;
    logic [CW-1:0]       chead_inc, open_slot_c;
    logic [NW:0]         slot_sum;
    logic [NW-1:0]       open_cnt;
    logic [LEN_W-1:0]    len_sat, first_cnt;
    logic [RW-1:0]       rem_after;
    logic [TIME_W-1:0]   age;

    always_comb
    begin
        out_free    = !out_valid_reg || !out_stall;
        full        = total_reg >= RW'(CAPACITY);
        chunks_full = count_reg >= NW'(MAX_CHUNKS);
        open_cnt    = {{(NW-1){1'b0}}, open_reg};
        has_closed  = count_reg > open_cnt;
        age         = in_time_reg - time_rd_reg;
        expired     = (time_rd_reg > in_time_reg) || (age >= max_age_reg);
        over        = full;
        drop_c      = (in_len_reg != '0) && has_closed && expired;
        read_done_c = (in_len_reg == '0) || gap_reg || !has_closed;
        emit_c      = (state_reg == S_A_WRITE) || (state_reg == S_R_BYTE)
                      || (state_reg == S_R_CHK && !drop_c && read_done_c);
        drop_sum    = (RW+1)'(byte_head_reg) + (RW+1)'(rem_rd_reg);
        drop_head   = (drop_sum >= (RW+1)'(CAPACITY)) ? AW'(drop_sum - (RW+1)'(CAPACITY))
                                                      : AW'(drop_sum);
        head_inc    = (byte_head_reg == AW'(CAPACITY-1)) ? '0 : byte_head_reg + 1'b1;
        tail_inc    = (byte_tail_reg == AW'(CAPACITY-1)) ? '0 : byte_tail_reg + 1'b1;
        chead_inc   = (chunk_head_reg == CW'(MAX_CHUNKS-1)) ? '0 : chunk_head_reg + 1'b1;
        slot_sum    = (NW+1)'(chunk_head_reg) + (NW+1)'(count_reg);
        open_slot_c = (slot_sum >= (NW+1)'(MAX_CHUNKS)) ? CW'(slot_sum - (NW+1)'(MAX_CHUNKS))
                                                        : CW'(slot_sum);
        len_sat     = (in_len_reg > LEN_W'(MAX_READ)) ? LEN_W'(MAX_READ) : in_len_reg;
        first_cnt   = (rem_rd_reg < RW'(len_sat)) ? LEN_W'(rem_rd_reg) : len_sat;
        rem_after   = front_rem_reg - 1'b1;
    end

    // chunk table and byte store, read at the current heads every cycle
    always_ff @(posedge clk)
    begin
        byte_rd_reg <= byte_mem[byte_head_reg];
        time_rd_reg <= time_mem[chunk_head_reg];
        rem_rd_reg  <= rem_mem[chunk_head_reg];
        if (state_reg == S_A_WRITE && out_free)
        begin
            byte_mem[byte_tail_reg] <= in_byte_reg;
        end
        if (state_reg == S_A_OPEN && !open_reg && !chunks_full)
        begin
            time_mem[open_slot_c] <= in_time_reg;
        end
        if (state_reg == S_A_WRITE && out_free)
        begin
            rem_mem[open_slot_reg] <= over ? open_rem_reg : open_rem_reg + 1'b1;
        end
        else if (state_reg == S_R_BYTE && out_free)
        begin
            rem_mem[chunk_head_reg] <= rem_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_IDLE;
            byte_head_reg  <= '0;
            byte_tail_reg  <= '0;
            chunk_head_reg <= '0;
            count_reg      <= '0;
            total_reg      <= '0;
            gap_reg        <= 1'b0;
            open_reg       <= 1'b0;
            hold_reg       <= 1'b0;
            max_age_reg    <= TIME_W'(1000000);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                max_age_reg <= cfg_data;
            end
            if (out_free)
            begin
                out_valid_reg <= emit_c;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        in_byte_reg <= data_byte;
                        in_end_reg  <= chunk_end;
                        in_time_reg <= time_us;
                        in_len_reg  <= read_length;
                        if (opcode == OP_APPEND)
                        begin
                            if (!open_reg)
                            begin
                                hold_reg <= (count_reg == '0) && !gap_reg;
                            end
                            state_reg <= S_A_OPEN;
                        end
                        else
                        begin
                            state_reg <= S_R_CHK;
                        end
                    end
                end
                S_A_OPEN:
                begin
                    if (open_reg)
                    begin
                        state_reg <= S_A_ROOM;
                    end
                    else if (chunks_full)
                    begin
                        total_reg      <= total_reg - rem_rd_reg;
                        byte_head_reg  <= drop_head;
                        chunk_head_reg <= chead_inc;
                        count_reg      <= count_reg - 1'b1;
                        gap_reg        <= 1'b1;
                        ret_reg        <= S_A_OPEN;
                        state_reg      <= S_DWAIT;
                    end
                    else
                    begin
                        open_slot_reg <= open_slot_c;
                        open_time_reg <= in_time_reg;
                        open_rem_reg  <= '0;
                        count_reg     <= count_reg + 1'b1;
                        open_reg      <= 1'b1;
                        state_reg     <= S_A_ROOM;
                    end
                end
                S_A_ROOM:
                begin
                    if (count_reg > NW'(1) && full)
                    begin
                        total_reg      <= total_reg - rem_rd_reg;
                        byte_head_reg  <= drop_head;
                        chunk_head_reg <= chead_inc;
                        count_reg      <= count_reg - 1'b1;
                        gap_reg        <= 1'b1;
                        ret_reg        <= S_A_ROOM;
                        state_reg      <= S_DWAIT;
                    end
                    else
                    begin
                        state_reg <= S_A_WRITE;
                    end
                end
                S_A_WRITE:
                begin
                    if (out_free)
                    begin
                        // full single chunk: its oldest byte goes
                        if (over)
                        begin
                            byte_head_reg <= head_inc;
                            gap_reg       <= 1'b1;
                        end
                        else
                        begin
                            open_rem_reg <= open_rem_reg + 1'b1;
                            total_reg    <= total_reg + 1'b1;
                        end
                        byte_tail_reg  <= tail_inc;
                        out_kind_reg   <= KIND_APPEND;
                        out_byte_reg   <= '0;
                        out_time_reg   <= open_time_reg;
                        out_notify_reg <= in_end_reg && hold_reg;
                        out_last_reg   <= 1'b1;
                        out_total_reg  <= over ? total_reg : total_reg + 1'b1;
                        out_gap_reg    <= gap_reg || over;
                        if (in_end_reg)
                        begin
                            open_reg <= 1'b0;
                            hold_reg <= 1'b0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                S_R_CHK:
                begin
                    if (drop_c)
                    begin
                        total_reg      <= total_reg - rem_rd_reg;
                        byte_head_reg  <= drop_head;
                        chunk_head_reg <= chead_inc;
                        count_reg      <= count_reg - 1'b1;
                        gap_reg        <= 1'b1;
                        ret_reg        <= S_R_CHK;
                        state_reg      <= S_DWAIT;
                    end
                    else if (out_free)
                    begin
                        if (read_done_c)
                        begin
                            out_byte_reg   <= '0;
                            out_notify_reg <= 1'b0;
                            out_last_reg   <= 1'b1;
                            out_total_reg  <= total_reg;
                            state_reg      <= S_IDLE;
                            if (in_len_reg == '0 || !gap_reg)
                            begin
                                out_kind_reg <= KIND_NONE;
                                out_time_reg <= '0;
                                out_gap_reg  <= gap_reg;
                            end
                            else
                            begin
                                gap_reg      <= 1'b0;
                                out_kind_reg <= KIND_GAP;
                                out_time_reg <= in_time_reg;
                                out_gap_reg  <= 1'b0;
                            end
                        end
                        else
                        begin
                            cnt_reg        <= first_cnt;
                            front_rem_reg  <= rem_rd_reg;
                            front_time_reg <= time_rd_reg;
                            state_reg      <= S_R_BYTE;
                        end
                    end
                end
                S_R_BYTE:
                begin
                    if (out_free)
                    begin
                        byte_head_reg  <= head_inc;
                        total_reg      <= total_reg - 1'b1;
                        front_rem_reg  <= rem_after;
                        cnt_reg        <= cnt_reg - 1'b1;
                        if (rem_after == '0)
                        begin
                            chunk_head_reg <= chead_inc;
                            count_reg      <= count_reg - 1'b1;
                        end
                        out_kind_reg   <= KIND_DATA;
                        out_byte_reg   <= byte_rd_reg;
                        out_time_reg   <= front_time_reg;
                        out_notify_reg <= 1'b0;
                        out_last_reg   <= (cnt_reg == LEN_W'(1));
                        out_total_reg  <= total_reg - 1'b1;
                        out_gap_reg    <= gap_reg;
                        state_reg      <= (cnt_reg == LEN_W'(1)) ? S_IDLE : S_R_BWAIT;
                    end
                end
                S_R_BWAIT:
                begin
                    // byte memory output catches up with the new head
                    state_reg <= S_R_BYTE;
                end
                S_DWAIT:
                begin
                    state_reg <= ret_reg;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign cfg_ready      = 1'b1;
    assign out_valid      = out_valid_reg;
    assign kind           = out_kind_reg;
    assign out_byte       = out_byte_reg;
    assign out_time_us    = out_time_reg;
    assign notify         = out_notify_reg;
    assign last           = out_last_reg;
    assign buffered_bytes = out_total_reg;
    assign gap_pending    = out_gap_reg;

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= RW'(CAPACITY))
        else $error("byte count above capacity");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NW'(MAX_CHUNKS))
        else $error("chunk count above limit");

    a_empty_no_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> total_reg == '0 && !open_reg)
        else $error("bytes held without a chunk");

    a_ptr_span: assert property (@(posedge clk) disable iff (!rst_n)
        ((RW+1)'(byte_head_reg) + (RW+1)'(total_reg) == (RW+1)'(byte_tail_reg))
        || ((RW+1)'(byte_head_reg) + (RW+1)'(total_reg)
            == (RW+1)'(byte_tail_reg) + (RW+1)'(CAPACITY)))
        else $error("byte pointers disagree with byte count");

    a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg)
        else $error("pending result lost");

endmodule
`default_nettype wire

/* sim/tb_timestamped_chunk_byte_fifo.sv */
// ----------------------------------------------------------------------------
// tb_timestamped_chunk_byte_fifo
// Self-checking bench for the timestamped chunk byte FIFO. A queue of byte
// appends and read requests feeds a clocked driver. A clocked monitor checks
// every result beat against a predicted copy of the FIFO. Both sides stall at
// random. The run walks through several max_age_us settings and fills the
// chunk table past its limit.
// ----------------------------------------------------------------------------
module tb_timestamped_chunk_byte_fifo;
    import tcbf_pkg::*;

    localparam int CAP     = 4096;
    localparam int NCHUNK  = 64;
    localparam int MAXRD   = 64;
    localparam int WD_LIMIT = 5000;

    typedef struct {
        logic        op;
        logic [7:0]  data;
        logic        ce;
        logic [63:0] t;
        logic [6:0]  len;
    } item_t;

    typedef struct {
        kind_t       kind;
        logic [7:0]  b;
        logic [63:0] t;
        logic        notify;
        logic        last;
        logic [12:0] held;
        logic        gap;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        opcode;
    logic [7:0]  data_byte;
    logic        chunk_end;
    logic [63:0] time_us;
    logic [6:0]  read_length;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [63:0] out_time_us;
    logic        notify;
    logic        last;
    logic [12:0] buffered_bytes;
    logic        gap_pending;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [63:0] cfg_data;

    timestamped_chunk_byte_fifo i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .data_byte(data_byte), .chunk_end(chunk_end),
        .time_us(time_us), .read_length(read_length),
        .out_valid(out_valid), .out_stall(out_stall),
        .kind(kind), .out_byte(out_byte), .out_time_us(out_time_us),
        .notify(notify), .last(last), .buffered_bytes(buffered_bytes),
        .gap_pending(gap_pending),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    item_t   pending_q[$];
    result_t want_q[$];
    int      errors;
    bit      calm;
    bit      hold_req;
    logic [63:0] now_us;

    // predicted fifo contents
    logic [63:0] age_limit;
    logic [7:0]  p_bytes [CAP];
    logic [63:0] p_ctime [NCHUNK];
    int          p_crem  [NCHUNK];
    int p_bhead, p_btail, p_chead, p_ccount, p_total;
    bit p_gap, p_open, p_nhold;

    function automatic void push_result(kind_t k, logic [7:0] b, logic [63:0] t,
                                        logic n, logic l);
        result_t r;
        r.kind = k; r.b = b; r.t = t; r.notify = n; r.last = l;
        r.held = p_total[12:0]; r.gap = p_gap;
        want_q = {want_q, r};
    endfunction

    function automatic void evict_head();
        int n;
        n = p_crem[p_chead];
        p_total -= n;
        p_bhead = (p_bhead + n) % CAP;
        p_chead = (p_chead + 1) % NCHUNK;
        p_ccount--;
        p_gap = 1;
    endfunction

    function automatic void predict_beat(item_t it);
        int slot, len, cnt, floor_n;
        logic [63:0] t;
        logic [7:0] b;
        if (it.op == OP_APPEND) begin
            if (!p_open) begin
                p_nhold = (p_ccount == 0) && !p_gap;
                while (p_ccount > 0 && p_ccount >= NCHUNK) evict_head();
                slot = (p_chead + p_ccount) % NCHUNK;
                p_ctime[slot] = it.t;
                p_crem[slot] = 0;
                p_ccount++;
                p_open = 1;
            end
            slot = (p_chead + p_ccount - 1) % NCHUNK;
            while (p_ccount > 1 && p_total + 1 > CAP) evict_head();
            if (p_total + 1 > CAP) begin
                // the open chunk alone is full: lose its oldest byte
                p_bhead = (p_bhead + 1) % CAP;
                p_crem[slot]--;
                p_total--;
                p_gap = 1;
            end
            p_bytes[p_btail] = it.data;
            p_btail = (p_btail + 1) % CAP;
            p_crem[slot]++;
            p_total++;
            b = 8'd0;
            if (it.ce) begin
                p_open = 0;
                b = {7'd0, p_nhold};
                p_nhold = 0;
            end
            push_result(KIND_APPEND, 8'd0, p_ctime[slot], b[0], 1'b1);
            return;
        end
        len = int'(it.len);
        if (len == 0) begin
            push_result(KIND_NONE, 8'd0, 64'd0, 1'b0, 1'b1);
            return;
        end
        if (len > MAXRD) len = MAXRD;
        floor_n = p_open ? 1 : 0;
        while (p_ccount > floor_n) begin
            t = p_ctime[p_chead];
            if (!(t > it.t || it.t - t >= age_limit)) break;
            evict_head();
        end
        if (p_gap) begin
            p_gap = 0;
            push_result(KIND_GAP, 8'd0, it.t, 1'b0, 1'b1);
            return;
        end
        if (p_ccount <= floor_n) begin
            push_result(KIND_NONE, 8'd0, 64'd0, 1'b0, 1'b1);
            return;
        end
        t = p_ctime[p_chead];
        cnt = p_crem[p_chead];
        if (cnt > len) cnt = len;
        for (int i = 0; i < cnt; i++) begin
            b = p_bytes[p_bhead];
            p_bhead = (p_bhead + 1) % CAP;
            p_crem[p_chead]--;
            p_total--;
            if (p_crem[p_chead] == 0) begin
                p_chead = (p_chead + 1) % NCHUNK;
                p_ccount--;
            end
            push_result(KIND_DATA, b, t, 1'b0, (i + 1 == cnt));
        end
    endfunction

    function automatic void add_beat(logic op, logic [7:0] d, logic ce,
                                     logic [63:0] t, logic [6:0] len);
        item_t it;
        it.op = op; it.data = d; it.ce = ce; it.t = t; it.len = len;
        pending_q = {pending_q, it};
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // mostly well-formed chunks and reads near the running clock, some noise
    function automatic void add_random(int n);
        int c, r, sz;
        c = 0;
        while (c < n) begin
            r = $urandom_range(99);
            if (r < 50) begin
                sz = ($urandom_range(19) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 6);
                for (int i = 0; i < sz; i++) begin
                    add_beat(OP_APPEND, 8'($urandom()), (i == sz - 1), now_us, 7'd0);
                    if ($urandom_range(9) == 0)
                        add_beat(OP_READ, 8'd0, 1'b0, now_us, 7'($urandom_range(1, 64)));
                    now_us += 64'($urandom_range(0, 3));
                end
                c += sz;
            end else if (r < 90) begin
                add_beat(OP_READ, 8'($urandom()), 1'($urandom()),
                         now_us + 64'($urandom_range(0, 40)),
                         ($urandom_range(7) == 0) ? 7'($urandom_range(0, 127))
                                                  : 7'($urandom_range(1, 64)));
                c++;
            end else if (r < 95) begin
                add_beat(OP_APPEND, 8'($urandom()), 1'b1, rand64(), 7'($urandom()));
                c++;
            end else begin
                add_beat(OP_READ, 8'd0, 1'b0, rand64(), 7'($urandom()));
                c++;
            end
            now_us += 64'($urandom_range(0, 30));
        end
    endfunction

    task automatic wait_drained();
        while (pending_q.size() != 0 || in_valid || want_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_age(logic [63:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        age_limit = v;
        cfg_valid <= 1'b0;
        cfg_data  <= rand64();
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        item_t it;
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            opcode      <= OP_APPEND;
            data_byte   <= 8'd0;
            chunk_end   <= 1'b0;
            time_us     <= 64'd0;
            read_length <= 7'd0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                it.op = opcode; it.data = data_byte; it.ce = chunk_end;
                it.t = time_us; it.len = read_length;
                predict_beat(it);
            end
            if (!(in_valid && in_stall))
            begin
                if (pending_q.size() != 0 && (calm || $urandom_range(99) >= 13))
                begin
                    it = pending_q[0];
                    pending_q.delete(0);
                    in_valid    <= 1'b1;
                    opcode      <= it.op;
                    data_byte   <= it.data;
                    chunk_end   <= it.ce;
                    time_us     <= it.t;
                    read_length <= it.len;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stall
    int  hold_cnt;
    bit  hold_done;
    always @(posedge clk or negedge rst_n)
    begin
        result_t w;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_cnt  = 0;
            hold_done = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (want_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: expected no result beat, actual kind %0d", $time, kind);
                end
                else
                begin
                    w = want_q[0];
                    want_q.delete(0);
                    if (kind !== w.kind || out_byte !== w.b || out_time_us !== w.t ||
                        notify !== w.notify || last !== w.last ||
                        buffered_bytes !== w.held || gap_pending !== w.gap)
                    begin
                        errors++;
                        $display(
                    "%0t: expected kind %0d byte %h time %h notify %b last %b held %0d gap %b",
                            $time, w.kind, w.b, w.t, w.notify, w.last, w.held, w.gap);
                        $display(
                    "%0t: actual   kind %0d byte %h time %h notify %b last %b held %0d gap %b",
                            $time, kind, out_byte, out_time_us, notify, last,
                            buffered_bytes, gap_pending);
                    end
                end
            end
            if (hold_req && !hold_done)
            begin
                hold_cnt  = 400;
                hold_done = 1;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !calm && ($urandom_range(99) < 13);
        end
    end

    // watchdog on cycles without any accepted beat
    int idle_cycles;
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        errors    = 0;
        calm      = 0;
        hold_req  = 0;
        cfg_valid = 1'b0;
        cfg_data  = 64'd0;
        age_limit = 64'd1000000;
        p_bhead = 0; p_btail = 0; p_chead = 0; p_ccount = 0; p_total = 0;
        p_gap = 0; p_open = 0; p_nhold = 0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        write_age(64'd1000000);
        // directed: empty reads, zero and oversize length, open chunk,
        // later-byte stamps, future stamp, expiry, extreme values
        add_beat(OP_READ, 8'h00, 1'b0, 64'd0, 7'd1);
        add_beat(OP_READ, 8'hff, 1'b1, 64'd5, 7'd0);
        add_beat(OP_APPEND, 8'h00, 1'b1, 64'd0, 7'd0);
        add_beat(OP_APPEND, 8'hff, 1'b0, 64'd10, 7'd127);
        add_beat(OP_APPEND, 8'ha5, 1'b0, 64'd999, 7'd0);
        add_beat(OP_READ, 8'h00, 1'b0, 64'd20, 7'd127);
        add_beat(OP_READ, 8'h00, 1'b0, 64'd20, 7'd127);
        add_beat(OP_APPEND, 8'h5a, 1'b1, 64'hffff_ffff_ffff_ffff, 7'd0);
        add_beat(OP_READ, 8'h00, 1'b0, 64'd30, 7'd1);
        add_beat(OP_READ, 8'h00, 1'b0, 64'd30, 7'd64);
        add_beat(OP_APPEND, 8'h11, 1'b1, 64'd100, 7'd0);
        add_beat(OP_READ, 8'h00, 1'b0, 64'd50, 7'd64);
        add_beat(OP_READ, 8'h00, 1'b0, 64'd50, 7'd64);
        add_beat(OP_APPEND, 8'h22, 1'b1, 64'd100, 7'd0);
        add_beat(OP_READ, 8'h00, 1'b0, 64'd1000100, 7'd64);
        add_beat(OP_READ, 8'h00, 1'b0, 64'hffff_ffff_ffff_ffff, 7'd65);
        add_beat(OP_READ, 8'h00, 1'b0, 64'h8000_0000_0000_0000, 7'd64);
        wait_drained();

        // chunk table overflow with one-byte chunks
        write_age(64'hffff_ffff_ffff_ffff);
        for (int i = 0; i < NCHUNK + 3; i++)
            add_beat(OP_APPEND, 8'($urandom()), 1'b1, 64'd200 + 64'(i), 7'd0);
        for (int i = 0; i < 4; i++)
            add_beat(OP_READ, 8'h00, 1'b0, 64'd300, 7'd64);
        wait_drained();

        // random phases over several ages; one without idling, one with a long hold
        now_us = rand64() >> 1;
        write_age(64'd50);
        hold_req <= 1'b1;
        add_random(45);
        wait_drained();
        write_age(64'd0);
        add_random(30);
        wait_drained();
        write_age(64'hffff_ffff_ffff_ffff);
        calm = 1;
        add_random(40);
        wait_drained();
        calm = 0;
        write_age(64'd1000000);
        add_random(50);
        wait_drained();
        repeat (50) @(posedge clk);

        if (errors == 0 && want_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* files.f */
design/tcbf_pkg.sv
design/timestamped_chunk_byte_fifo.sv
sim/tb_timestamped_chunk_byte_fifo.sv
